// ===== src/bf4_pkg.sv =====
// ----------------------------------------------------------------------------
// bf4_pkg
// Shared types, constants and helpers for the 4-way boundary fill block.
// ----------------------------------------------------------------------------
`default_nettype none

package bf4_pkg;

  localparam int FRAME_WIDTH  = 256;
  localparam int FRAME_HEIGHT = 256;
  localparam int PIX_COUNT    = FRAME_WIDTH * FRAME_HEIGHT;

  localparam int ADDR_W  = $clog2(PIX_COUNT);
  localparam int SP_W    = $clog2(PIX_COUNT + 1);
  localparam int X_W     = $clog2(FRAME_WIDTH);
  localparam int Y_W     = $clog2(FRAME_HEIGHT);
  localparam int COORD_W = 8;
  localparam int COLOR_W = 24;
  localparam int COUNT_W = 17;
  localparam int KIND_W  = 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam int                 CHAN_MAX  = 255;

  localparam logic [COLOR_W-1:0] FILL_RESET   = COLOR_W'(CHAN_MAX << 16);
  localparam logic [COLOR_W-1:0] BORDER_RESET = '0;

  localparam logic REG_FILL_COLOR   = 1'b0;
  localparam logic REG_BORDER_COLOR = 1'b1;

  localparam logic RES_READ = 1'b0;
  localparam logic RES_FILL = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_WRITE = 2'd0,
    KIND_FILL  = 2'd1,
    KIND_READ  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    DIR_XP = 2'd0,
    DIR_XM = 2'd1,
    DIR_YP = 2'd2,
    DIR_YM = 2'd3
  } dir_t;

  typedef struct packed {
    logic [Y_W-1:0] y;
    logic [X_W-1:0] x;
  } point_t;

  localparam int POINT_W = $bits(point_t);

  typedef struct packed {
    logic   ok;
    point_t pt;
  } nbr_t;

  typedef struct packed {
    logic               we;
    logic [ADDR_W-1:0]  waddr;
    logic [COLOR_W-1:0] wdata;
    logic [ADDR_W-1:0]  raddr;
  } frame_req_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    point_t            wdata;
    logic [ADDR_W-1:0] raddr;
  } stack_req_t;

  function automatic logic [ADDR_W-1:0] frame_addr(point_t p);
    frame_addr = ADDR_W'(int'(p.y) * FRAME_WIDTH + int'(p.x));
  endfunction

  function automatic nbr_t nbr_point(point_t p, dir_t d);
    nbr_t         r;
    logic [X_W:0] xw;
    logic [Y_W:0] yw;
    logic         ok;
    xw = {1'b0, p.x};
    yw = {1'b0, p.y};
    ok = 1'b1;
    case (d)
      DIR_XP: xw = xw + 1'b1;
      DIR_XM: begin
        ok = (p.x != '0);
        xw = xw - 1'b1;
      end
      DIR_YP: yw = yw + 1'b1;
      default: begin
        ok = (p.y != '0);
        yw = yw - 1'b1;
      end
    endcase
    r.ok   = ok && (int'(xw) < FRAME_WIDTH) && (int'(yw) < FRAME_HEIGHT);
    r.pt.x = X_W'(xw);
    r.pt.y = Y_W'(yw);
    nbr_point = r;
  endfunction

endpackage

`default_nettype wire

// ===== src/bf4_ram.sv =====
// ----------------------------------------------------------------------------
// bf4_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bf4_ram #(
  parameter int DATA_W = 24,
  parameter int ADDR_W = 16
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/bf4_ctrl.sv =====
// ----------------------------------------------------------------------------
// bf4_ctrl
// Item sequencer: pixel read/write, stack-driven fill walk, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bf4_ctrl (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [bf4_pkg::KIND_W-1:0]      kind,
  input  wire logic [bf4_pkg::COORD_W-1:0]     coord_x,
  input  wire logic [bf4_pkg::COORD_W-1:0]     coord_y,
  input  wire logic [bf4_pkg::COLOR_W-1:0]     pixel_value,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic                                 result_kind,
  output logic      [bf4_pkg::COLOR_W-1:0]     read_value,
  output logic      [bf4_pkg::COUNT_W-1:0]     painted_count,
  input  wire logic [bf4_pkg::COLOR_W-1:0]     fill_color,
  input  wire logic [bf4_pkg::COLOR_W-1:0]     border_color,
  output bf4_pkg::frame_req_t                  frame_req,
  input  wire logic [bf4_pkg::COLOR_W-1:0]     frame_rdata,
  output bf4_pkg::stack_req_t                  stack_req,
  input  wire logic [bf4_pkg::POINT_W-1:0]     stack_rdata
);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_RD_WAIT  = 7'b0000010,
    S_SEED_CHK = 7'b0000100,
    S_POP      = 7'b0001000,
    S_POP_WAIT = 7'b0010000,
    S_NBR_RD   = 7'b0100000,
    S_NBR_CHK  = 7'b1000000
  } state_t;

  state_t                         state;
  logic [bf4_pkg::COUNT_W-1:0]    count;
  logic [bf4_pkg::SP_W-1:0]       sp;
  bf4_pkg::point_t                cur;
  bf4_pkg::point_t                cand;
  bf4_pkg::dir_t                  nbr;

  logic                           accept;
  logic                           in_inside;
  bf4_pkg::point_t                in_pt;
  logic                           paintable;
  logic                           can_push;
  logic                           chk;
  bf4_pkg::point_t                base;
  bf4_pkg::dir_t                  dir_sel;
  bf4_pkg::dir_t                  nbr_inc;
  bf4_pkg::nbr_t                  nb;
  logic [bf4_pkg::COUNT_W-1:0]    count_inc;

  assign in_ready  = (state == S_IDLE) && (!out_valid || out_ready);
  assign accept    = in_valid && in_ready;
  assign in_inside = (int'(coord_x) < bf4_pkg::FRAME_WIDTH) &&
                     (int'(coord_y) < bf4_pkg::FRAME_HEIGHT);
  assign in_pt.x   = bf4_pkg::X_W'(coord_x);
  assign in_pt.y   = bf4_pkg::Y_W'(coord_y);

  assign paintable = (frame_rdata != fill_color) && (frame_rdata != border_color);
  assign can_push  = sp < bf4_pkg::SP_W'(bf4_pkg::PIX_COUNT);
  assign chk       = (state == S_SEED_CHK) || (state == S_NBR_CHK);
  assign count_inc = (count != bf4_pkg::COUNT_MAX) ? count + 1'b1 : count;
  assign nbr_inc   = bf4_pkg::dir_t'(nbr + 2'd1);

  always_comb begin
    case (state)
      S_POP_WAIT: begin
        base    = bf4_pkg::point_t'(stack_rdata);
        dir_sel = bf4_pkg::DIR_XP;
      end
      S_NBR_CHK: begin
        base    = cur;
        dir_sel = nbr_inc;
      end
      default: begin
        base    = cur;
        dir_sel = nbr;
      end
    endcase
    nb = bf4_pkg::nbr_point(base, dir_sel);
  end

  always_comb begin
    frame_req.we    = chk && paintable;
    frame_req.waddr = bf4_pkg::frame_addr(cand);
    frame_req.wdata = fill_color;
    frame_req.raddr = bf4_pkg::frame_addr(nb.pt);
    if (state == S_IDLE) begin
      frame_req.we    = accept && (kind == bf4_pkg::KIND_WRITE) && in_inside;
      frame_req.waddr = bf4_pkg::frame_addr(in_pt);
      frame_req.wdata = pixel_value;
      frame_req.raddr = bf4_pkg::frame_addr(in_pt);
    end
  end

  always_comb begin
    stack_req.we    = chk && paintable && can_push;
    stack_req.waddr = sp[bf4_pkg::ADDR_W-1:0];
    stack_req.wdata = cand;
    stack_req.raddr = bf4_pkg::ADDR_W'(sp - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      count     <= '0;
      sp        <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (bf4_pkg::kind_t'(kind))
              bf4_pkg::KIND_FILL: begin
                count <= '0;
                sp    <= '0;
                cand  <= in_pt;
                if (in_inside) begin
                  state <= S_SEED_CHK;
                end else begin
                  out_valid     <= 1'b1;
                  result_kind   <= bf4_pkg::RES_FILL;
                  read_value    <= '0;
                  painted_count <= '0;
                end
              end
              bf4_pkg::KIND_READ: begin
                if (in_inside) begin
                  state <= S_RD_WAIT;
                end else begin
                  out_valid     <= 1'b1;
                  result_kind   <= bf4_pkg::RES_READ;
                  read_value    <= '0;
                  painted_count <= '0;
                end
              end
              default: ;
            endcase
          end
        end
        S_RD_WAIT: begin
          out_valid     <= 1'b1;
          result_kind   <= bf4_pkg::RES_READ;
          read_value    <= frame_rdata;
          painted_count <= '0;
          state         <= S_IDLE;
        end
        S_SEED_CHK: begin
          if (paintable) begin
            count <= count_inc;
            if (can_push) begin
              sp <= sp + 1'b1;
            end
          end
          state <= S_POP;
        end
        S_POP: begin
          if (sp == '0) begin
            out_valid     <= 1'b1;
            result_kind   <= bf4_pkg::RES_FILL;
            read_value    <= '0;
            painted_count <= count;
            state         <= S_IDLE;
          end else begin
            sp    <= sp - 1'b1;
            state <= S_POP_WAIT;
          end
        end
        S_POP_WAIT: begin
          cur  <= bf4_pkg::point_t'(stack_rdata);
          cand <= nb.pt;
          if (nb.ok) begin
            nbr   <= bf4_pkg::DIR_XP;
            state <= S_NBR_CHK;
          end else begin
            nbr   <= bf4_pkg::DIR_XM;
            state <= S_NBR_RD;
          end
        end
        S_NBR_RD: begin
          cand <= nb.pt;
          if (nb.ok) begin
            state <= S_NBR_CHK;
          end else if (nbr == bf4_pkg::DIR_YM) begin
            state <= S_POP;
          end else begin
            nbr <= nbr_inc;
          end
        end
        S_NBR_CHK: begin
          if (paintable) begin
            count <= count_inc;
            if (can_push) begin
              sp <= sp + 1'b1;
            end
          end
          if (nbr == bf4_pkg::DIR_YM) begin
            state <= S_POP;
          end else begin
            nbr  <= nbr_inc;
            cand <= nb.pt;
            if (!nb.ok) begin
              state <= S_NBR_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/boundary_fill_4way.sv =====
// ----------------------------------------------------------------------------
// boundary_fill_4way
// Frame store of 24-bit RGB pixels with a 4-connected boundary fill.
//
// Input channel (in_valid/in_ready) carries kind, coord_x, coord_y and
// pixel_value. A write stores one pixel and gives no result. A read
// returns the pixel (zero outside the frame) via the frame RAM read
// register and the result register. A fill repaints the region around
// the seed in fill_color, stopping at border_color, fill_color and the
// frame edges, then reports painted_count. Each painted pixel costs one
// stack read, then one frame-store read/check per neighbor, pipelined
// through the single read port of the frame RAM.
// Output channel (out_valid/out_ready) holds one result in a register; the
// next item is taken in the cycle that result transfers. A stalled receiver
// holds the result and blocks the input channel until it transfers.
// Config port: cfg_we writes cfg_data into fill_color (index 0) or
// border_color (index 1); write only while the block is idle.
// Reset clears control state, sets fill_color to FILL_RESET and clears
// border_color; the frame store is undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module boundary_fill_4way (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [bf4_pkg::KIND_W-1:0]    kind,
  input  wire logic [bf4_pkg::COORD_W-1:0]   coord_x,
  input  wire logic [bf4_pkg::COORD_W-1:0]   coord_y,
  input  wire logic [bf4_pkg::COLOR_W-1:0]   pixel_value,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               result_kind,
  output logic      [bf4_pkg::COLOR_W-1:0]   read_value,
  output logic      [bf4_pkg::COUNT_W-1:0]   painted_count,
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_index,
  input  wire logic [bf4_pkg::COLOR_W-1:0]   cfg_data
);

  logic [bf4_pkg::COLOR_W-1:0] fill_color;
  logic [bf4_pkg::COLOR_W-1:0] border_color;

  bf4_pkg::frame_req_t         frame_req;
  bf4_pkg::stack_req_t         stack_req;
  logic [bf4_pkg::COLOR_W-1:0] frame_rdata;
  logic [bf4_pkg::POINT_W-1:0] stack_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_color   <= bf4_pkg::FILL_RESET;
      border_color <= bf4_pkg::BORDER_RESET;
    end else if (cfg_we) begin
      if (cfg_index == bf4_pkg::REG_FILL_COLOR) begin
        fill_color <= cfg_data;
      end else begin
        border_color <= cfg_data;
      end
    end
  end

  bf4_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .kind          (kind),
    .coord_x       (coord_x),
    .coord_y       (coord_y),
    .pixel_value   (pixel_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .result_kind   (result_kind),
    .read_value    (read_value),
    .painted_count (painted_count),
    .fill_color    (fill_color),
    .border_color  (border_color),
    .frame_req     (frame_req),
    .frame_rdata   (frame_rdata),
    .stack_req     (stack_req),
    .stack_rdata   (stack_rdata)
  );

  bf4_ram #(
    .DATA_W (bf4_pkg::COLOR_W),
    .ADDR_W (bf4_pkg::ADDR_W)
  ) u_frame_ram (
    .clk   (clk),
    .we    (frame_req.we),
    .waddr (frame_req.waddr),
    .wdata (frame_req.wdata),
    .raddr (frame_req.raddr),
    .rdata (frame_rdata)
  );

  bf4_ram #(
    .DATA_W (bf4_pkg::POINT_W),
    .ADDR_W (bf4_pkg::ADDR_W)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stack_req.we),
    .waddr (stack_req.waddr),
    .wdata (stack_req.wdata),
    .raddr (stack_req.raddr),
    .rdata (stack_rdata)
  );

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for boundary_fill_4way
// Drives pixel writes, pixel reads and seeded fills with random idle gaps on
// both channels and checks every read value and painted count against an
// in-bench frame image. Before each fill the region is scanned and any
// never-written pixel it would touch is first written with the border color,
// so the fills and reads only use pixel values that have been written.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAME_WIDTH  = bf4_pkg::FRAME_WIDTH;
  localparam int FRAME_HEIGHT = bf4_pkg::FRAME_HEIGHT;
  localparam int PIX_COUNT    = bf4_pkg::PIX_COUNT;
  localparam int KIND_W       = bf4_pkg::KIND_W;
  localparam int COORD_W      = bf4_pkg::COORD_W;
  localparam int COLOR_W      = bf4_pkg::COLOR_W;
  localparam int COUNT_W      = bf4_pkg::COUNT_W;

  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int STALL_LIMIT   = 60000;
  localparam int ITEM_GOAL     = 1450;
  localparam int PHASES        = 7;

  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

  typedef struct packed {
    logic               rk;
    logic [COLOR_W-1:0] rv;
    logic [COUNT_W-1:0] cnt;
  } result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [KIND_W-1:0]    kind = '0;
  logic [COORD_W-1:0]   coord_x = '0;
  logic [COORD_W-1:0]   coord_y = '0;
  logic [COLOR_W-1:0]   pixel_value = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 result_kind;
  logic [COLOR_W-1:0]   read_value;
  logic [COUNT_W-1:0]   painted_count;
  logic                 cfg_we = 1'b0;
  logic                 cfg_index = 1'b0;
  logic [COLOR_W-1:0]   cfg_data = '0;

  logic [COLOR_W-1:0] frame_img   [PIX_COUNT];
  bit                 frame_known [PIX_COUNT];
  int                 probe_tag   [PIX_COUNT];
  int                 probe_serial = 0;
  int                 addr_trail[$];
  int                 unknown_rim[$];
  int                 written_addrs[$];
  int                 paint_total;
  logic [COLOR_W-1:0] cur_fill   = bf4_pkg::FILL_RESET;
  logic [COLOR_W-1:0] cur_border = bf4_pkg::BORDER_RESET;

  result_t read_fill_results[$];
  int      mismatches   = 0;
  int      sent_items   = 0;
  int      hold_request = 0;
  int      idle_cycles  = 0;
  bit      quiet        = 1'b0;

  boundary_fill_4way dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .coord_x      (coord_x),
    .coord_y      (coord_y),
    .pixel_value  (pixel_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_kind  (result_kind),
    .read_value   (read_value),
    .painted_count(painted_count),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic void paint_pixel(int x, int y);
    int a;
    if (x < 0 || y < 0 || x >= FRAME_WIDTH || y >= FRAME_HEIGHT) return;
    a = y * FRAME_WIDTH + x;
    if (frame_img[a] == cur_fill || frame_img[a] == cur_border) return;
    frame_img[a] = cur_fill;
    paint_total++;
    addr_trail.push_back(a);
  endfunction

  function automatic logic [COUNT_W-1:0] paint_region(int x, int y);
    int a;
    int px;
    int py;
    paint_total = 0;
    addr_trail.delete();
    paint_pixel(x, y);
    while (addr_trail.size() > 0) begin
      a  = addr_trail.pop_back();
      px = a % FRAME_WIDTH;
      py = a / FRAME_WIDTH;
      paint_pixel(px + 1, py);
      paint_pixel(px - 1, py);
      paint_pixel(px, py + 1);
      paint_pixel(px, py - 1);
    end
    return paint_total[COUNT_W-1:0];
  endfunction

  // walk the region without painting; collect unwritten pixels it would read
  function automatic void probe_pixel(int x, int y);
    int a;
    if (x < 0 || y < 0 || x >= FRAME_WIDTH || y >= FRAME_HEIGHT) return;
    a = y * FRAME_WIDTH + x;
    if (probe_tag[a] == probe_serial) return;
    probe_tag[a] = probe_serial;
    if (!frame_known[a])
      unknown_rim.push_back(a);
    else if (frame_img[a] != cur_fill && frame_img[a] != cur_border)
      addr_trail.push_back(a);
  endfunction

  function automatic void probe_region(int x, int y);
    int a;
    int px;
    int py;
    probe_serial++;
    addr_trail.delete();
    unknown_rim.delete();
    probe_pixel(x, y);
    while (addr_trail.size() > 0) begin
      a  = addr_trail.pop_back();
      px = a % FRAME_WIDTH;
      py = a / FRAME_WIDTH;
      probe_pixel(px + 1, py);
      probe_pixel(px - 1, py);
      probe_pixel(px, py + 1);
      probe_pixel(px, py - 1);
    end
  endfunction

  function automatic void apply_transfer(logic [KIND_W-1:0] k, int x, int y,
                                         logic [COLOR_W-1:0] v);
    int      a;
    result_t r;
    a = y * FRAME_WIDTH + x;
    case (k)
      bf4_pkg::KIND_WRITE: begin
        frame_img[a] = v;
        if (!frame_known[a]) begin
          frame_known[a] = 1'b1;
          written_addrs.push_back(a);
        end
      end
      bf4_pkg::KIND_FILL: begin
        r.rk  = bf4_pkg::RES_FILL;
        r.rv  = '0;
        r.cnt = paint_region(x, y);
        read_fill_results.push_back(r);
      end
      bf4_pkg::KIND_READ: begin
        r.rk  = bf4_pkg::RES_READ;
        r.rv  = frame_img[a];
        r.cnt = '0;
        read_fill_results.push_back(r);
      end
      default: ;
    endcase
  endfunction

  task automatic send_item(logic [KIND_W-1:0] k, int x, int y, logic [COLOR_W-1:0] v);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    kind        <= k;
    coord_x     <= COORD_W'(x);
    coord_y     <= COORD_W'(y);
    pixel_value <= v;
    do @(posedge clk); while (!in_ready);
    apply_transfer(k, x, y, v);
    if (k != KIND_SPARE) sent_items++;
  endtask

  task automatic drain_block();
    in_valid <= 1'b0;
    while (read_fill_results.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_colors(logic [COLOR_W-1:0] f, logic [COLOR_W-1:0] b);
    drain_block();
    cfg_we    <= 1'b1;
    cfg_index <= bf4_pkg::REG_FILL_COLOR;
    cfg_data  <= f;
    @(posedge clk);
    cfg_index <= bf4_pkg::REG_BORDER_COLOR;
    cfg_data  <= b;
    @(posedge clk);
    cfg_we     <= 1'b0;
    cur_fill   = f;
    cur_border = b;
  endtask

  task automatic fill_at(int x, int y);
    int rim[$];
    probe_region(x, y);
    rim = unknown_rim;
    foreach (rim[i])
      send_item(bf4_pkg::KIND_WRITE, rim[i] % FRAME_WIDTH, rim[i] / FRAME_WIDTH,
                cur_border);
    send_item(bf4_pkg::KIND_FILL, x, y, COLOR_W'($urandom));
  endtask

  task automatic read_pixel(int x, int y);
    int a;
    a = y * FRAME_WIDTH + x;
    if (!frame_known[a])
      a = written_addrs[$urandom_range(0, written_addrs.size() - 1)];
    send_item(bf4_pkg::KIND_READ, a % FRAME_WIDTH, a / FRAME_WIDTH, COLOR_W'($urandom));
  endtask

  task automatic noise_item();
    int pick;
    int a;
    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      send_item(bf4_pkg::KIND_WRITE, $urandom_range(0, 255), $urandom_range(0, 255),
                COLOR_W'($urandom));
    end else if (pick < 7) begin
      read_pixel($urandom_range(0, 255), $urandom_range(0, 255));
    end else if (pick == 7) begin
      fill_at($urandom_range(0, 255), $urandom_range(0, 255));
    end else if (pick == 8) begin
      a = written_addrs[$urandom_range(0, written_addrs.size() - 1)];
      fill_at(a % FRAME_WIDTH, a / FRAME_WIDTH);
    end else begin
      send_item(KIND_SPARE, $urandom_range(0, 255), $urandom_range(0, 255),
                COLOR_W'($urandom));
    end
  endtask

  // outlined box, optionally with one side missing, then fills and reads in it and noise items
  task automatic run_scene();
    int                 x0;
    int                 y0;
    int                 w;
    int                 h;
    int                 open_side;
    bit                 on_rim;
    bit                 skip;
    logic [COLOR_W-1:0] bg;
    quiet = ($urandom_range(0, 3) == 0);
    x0 = $urandom_range(0, FRAME_WIDTH - 1);
    y0 = $urandom_range(0, FRAME_HEIGHT - 1);
    w  = $urandom_range(3, 10);
    h  = $urandom_range(3, 10);
    if (x0 + w > FRAME_WIDTH) w = FRAME_WIDTH - x0;
    if (y0 + h > FRAME_HEIGHT) h = FRAME_HEIGHT - y0;
    open_side = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : -1;
    bg = ($urandom_range(0, 7) == 0) ? cur_fill : COLOR_W'($urandom);
    for (int j = 0; j < h; j++) begin
      for (int i = 0; i < w; i++) begin
        on_rim = (i == 0 || j == 0 || i == w - 1 || j == h - 1);
        skip   = (open_side == 0 && j == 0) || (open_side == 1 && j == h - 1) ||
                 (open_side == 2 && i == 0) || (open_side == 3 && i == w - 1);
        if (on_rim && !skip)
          send_item(bf4_pkg::KIND_WRITE, x0 + i, y0 + j, cur_border);
        else if (!on_rim)
          send_item(bf4_pkg::KIND_WRITE, x0 + i, y0 + j,
                    ($urandom_range(0, 9) == 0) ? cur_border : bg);
      end
    end
    repeat ($urandom_range(1, 2))
      fill_at(x0 + $urandom_range(0, w - 1), y0 + $urandom_range(0, h - 1));
    repeat ($urandom_range(2, 5))
      read_pixel(x0 + $urandom_range(0, w - 1), y0 + $urandom_range(0, h - 1));
    repeat ($urandom_range(0, 4)) noise_item();
  endtask

  task automatic test_pixel_access();
    send_item(bf4_pkg::KIND_WRITE, 0, 0, 24'hFFFFFF);
    send_item(bf4_pkg::KIND_WRITE, 255, 0, 24'h000000);
    send_item(bf4_pkg::KIND_WRITE, 0, 255, 24'hA5A5A5);
    send_item(bf4_pkg::KIND_WRITE, 255, 255, 24'h5A5A5A);
    read_pixel(0, 0);
    read_pixel(255, 0);
    read_pixel(0, 255);
    send_item(KIND_SPARE, 255, 255, 24'hFFFFFF);
    read_pixel(255, 255);
  endtask

  task automatic test_fill_special_cases();
    send_item(bf4_pkg::KIND_WRITE, 128, 0, cur_fill);
    fill_at(128, 0);
    send_item(bf4_pkg::KIND_WRITE, 0, 128, cur_border);
    fill_at(0, 128);
    fill_at(255, 255);
    read_pixel(255, 255);
    fill_at(0, 255);
    read_pixel(0, 255);
  endtask

  task automatic test_random_scenes();
    int goal;
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: ;
        1: set_colors(24'h000000, 24'hFFFFFF);
        2: set_colors(24'hFFFFFF, 24'h000000);
        3: set_colors(24'h00FF00, 24'h00FF00);
        PHASES - 1: set_colors(bf4_pkg::FILL_RESET, bf4_pkg::BORDER_RESET);
        default: set_colors(COLOR_W'($urandom), COLOR_W'($urandom));
      endcase
      goal = sent_items + ITEM_GOAL / PHASES;
      while (sent_items < goal) run_scene();
    end
    quiet = 1'b0;
  endtask

  task automatic test_input_backpressure();
    quiet        = 1'b1;
    hold_request = HOLD_CYCLES;
    repeat (12) begin
      read_pixel($urandom_range(0, 255), $urandom_range(0, 255));
      send_item(bf4_pkg::KIND_WRITE, $urandom_range(0, 255), $urandom_range(0, 255),
                COLOR_W'($urandom));
    end
    quiet = 1'b0;
    drain_block();
  endtask

  initial begin
    int gap;
    while (rst) @(posedge clk);
    forever begin
      if (hold_request > 0) begin
        out_ready <= 1'b0;
        repeat (hold_request) @(posedge clk);
        hold_request = 0;
      end
      gap = quiet ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (read_fill_results.size() == 0) begin
        $error("unexpected transfer: result_kind %0d read_value %06h painted_count %0d",
               result_kind, read_value, painted_count);
        mismatches++;
      end else begin
        want = read_fill_results.pop_front();
        if (result_kind !== want.rk) begin
          $error("result_kind: expected %0d, got %0d", want.rk, result_kind);
          mismatches++;
        end
        if (read_value !== want.rv) begin
          $error("read_value: expected %06h, got %06h", want.rv, read_value);
          mismatches++;
        end
        if (painted_count !== want.cnt) begin
          $error("painted_count: expected %0d, got %0d", want.cnt, painted_count);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_pixel_access();
    test_fill_special_cases();
    test_random_scenes();
    test_input_backpressure();
    drain_block();
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

`default_nettype wire

// ===== boundary_fill_4way.f =====
src/bf4_pkg.sv
src/bf4_ram.sv
src/bf4_ctrl.sv
src/boundary_fill_4way.sv
test/tb.sv
